@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the servo ramp RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define SRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("servo ramp check failed");

// Next-cycle implication
`define SRP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("servo ramp check failed");

`endif

@@ rtl/core/srp_pkg.sv @@
// Package for the servo ramp interpolator: widths, reset values, register
// indexes, payload structs and the divider request/response types. No dependencies.
package srp_pkg;

    // Servo slots and the number actually driven
    localparam int SERVO_SLOTS    = 5;
    localparam int NUM_SERVOS     = 5;
    localparam int MAX_RAMP_STEPS = 63;

    // Field widths
    localparam int ANG_W      = 8;
    localparam int STEP_W     = 6;
    localparam int DUTY_W     = 14;
    localparam int CFG_W      = 14;
    localparam int IDX_W      = 3;
    localparam int SERVO_W    = 3;
    localparam int DIFF_W     = ANG_W + 1;
    localparam int SPAN_OUT_W = DUTY_W + 1;
    localparam int PROD_W     = DIFF_W + SPAN_OUT_W;
    // magnitude of (angle - angle_min) * span_out stays below 2^22
    localparam int DIV_W      = 22;
    localparam int DIVR_W     = ANG_W;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int PULSE_W    = DIV_W + 3;

    // Register indexes on the write port
    localparam logic [IDX_W-1:0] REG_RAMP_STEPS = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANGLE_MIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ANGLE_MAX  = 3'd2;
    localparam logic [IDX_W-1:0] REG_PULSE_MIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PULSE_MAX  = 3'd4;

    // Reset values of the registers
    localparam logic [STEP_W-1:0] RAMP_STEPS_RST = 6'd10;
    localparam logic [ANG_W-1:0]  ANGLE_MIN_RST  = 8'd0;
    localparam logic [ANG_W-1:0]  ANGLE_MAX_RST  = 8'd180;
    localparam logic [DUTY_W-1:0] PULSE_MIN_RST  = 14'd410;
    localparam logic [DUTY_W-1:0] PULSE_MAX_RST  = 14'd2048;

    // Input request: one target pose
    typedef struct packed {
        logic [ANG_W-1:0] target_a;
        logic [ANG_W-1:0] target_b;
        logic [ANG_W-1:0] target_c;
        logic [ANG_W-1:0] target_d;
        logic [ANG_W-1:0] target_e;
    } in_item_t;

    // Output request: one ramp step
    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_d;
        logic [DUTY_W-1:0] duty_e;
        logic [STEP_W-1:0] ramp_index;
        logic              last_step;
    } out_item_t;

    // Divider control
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVR_W-1:0] remainder;
    } div_rsp_t;

endpackage

@@ rtl/core/srp_div.sv @@
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on srp_pkg for widths and the request/response structs.
module srp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  srp_pkg::div_req_t req,
    output srp_pkg::div_rsp_t rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [srp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [srp_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [srp_pkg::DIVR_W-1:0]   rem_reg, rem_next;
    logic [srp_pkg::DIVR_W-1:0]   dsr_reg, dsr_next;
    logic [srp_pkg::DIVR_W:0]     trial;
    logic [srp_pkg::DIVR_W:0]     trial_sub;
    logic                         fits;

    // Trial subtraction of the divisor from the partial remainder
    assign trial     = {rem_reg, quo_reg[srp_pkg::DIV_W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign fits      = (trial >= {1'b0, dsr_reg});

    // Iteration control and datapath
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        priority if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = srp_pkg::CNT_W'(srp_pkg::DIV_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[srp_pkg::DIV_W-2:0], fits};
            rem_next = fits ? trial_sub[srp_pkg::DIVR_W-1:0] : trial[srp_pkg::DIVR_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ rtl/core/servo_ramp_pwm_interpolator.sv @@
// Servo pose ramp interpolator, on srp_pkg, srp_div and assert_macros.svh: angles to PWM duty.
// Each pose gives ramp_steps+1 results, zero counting as one; each result is computed only
// after the previous one is taken, by the shared restoring divider (22-bit quotient), two
// divisions per servo, one when angle_max equals angle_min. One pose at a time: in_stall
// stays high until the last result of a pose is taken.
// Reset: registers return to defaults, stored pose to zero, no result pending.
`include "assert_macros.svh"

module servo_ramp_pwm_interpolator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [srp_pkg::IDX_W-1:0]  cfg_index,
    input  logic [srp_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  srp_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output srp_pkg::out_item_t         out_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_A  = 3'd1;
    localparam logic [2:0] ST_GO_A   = 3'd2;
    localparam logic [2:0] ST_WAIT_A = 3'd3;
    localparam logic [2:0] ST_MUL_B  = 3'd4;
    localparam logic [2:0] ST_GO_B   = 3'd5;
    localparam logic [2:0] ST_WAIT_B = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    localparam logic [srp_pkg::SERVO_W-1:0] LAST_SERVO =
        srp_pkg::SERVO_W'(srp_pkg::NUM_SERVOS - 1);

    // Configuration registers
    logic [srp_pkg::STEP_W-1:0] ramp_steps_reg;
    logic [srp_pkg::ANG_W-1:0]  angle_min_reg;
    logic [srp_pkg::ANG_W-1:0]  angle_max_reg;
    logic [srp_pkg::DUTY_W-1:0] pulse_min_reg;
    logic [srp_pkg::DUTY_W-1:0] pulse_max_reg;

    // Sequencer and per-pose state
    logic [2:0]                   state_reg, state_next;
    logic [srp_pkg::SERVO_W-1:0]  servo_reg, servo_next;
    logic [srp_pkg::STEP_W-1:0]   k_reg, k_next;
    logic [srp_pkg::STEP_W-1:0]   steps_reg, steps_next;
    logic [srp_pkg::ANG_W-1:0]    prev_reg [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::ANG_W-1:0]    prev_next [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::ANG_W-1:0]    base_reg [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::ANG_W-1:0]    base_next [srp_pkg::SERVO_SLOTS];
    logic signed [srp_pkg::DIFF_W-1:0] diff_reg [srp_pkg::SERVO_SLOTS];
    logic signed [srp_pkg::DIFF_W-1:0] diff_next [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::DUTY_W-1:0]   duty_reg [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::DUTY_W-1:0]   duty_next [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::DUTY_W-1:0]   duty_out [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::ANG_W-1:0]    ang_reg, ang_next;
    logic signed [srp_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic [srp_pkg::ANG_W-1:0]    tgt [srp_pkg::SERVO_SLOTS];
    logic [srp_pkg::STEP_W-1:0]   steps_eff;
    logic                         accept;

    // Shared multiplier
    logic signed [srp_pkg::DIFF_W-1:0]     mul_a;
    logic signed [srp_pkg::SPAN_OUT_W-1:0] mul_b;
    logic signed [srp_pkg::PROD_W-1:0]     mul_p;

    // Mapping spans
    logic signed [srp_pkg::DIFF_W-1:0]     span_in;
    logic signed [srp_pkg::SPAN_OUT_W-1:0] span_out;
    logic                                  span_in_zero;
    logic [srp_pkg::DIFF_W-1:0]            span_in_abs;

    // Divider operands and result shaping
    srp_pkg::div_req_t            div_req;
    srp_pkg::div_rsp_t            div_rsp;
    logic                         prod_neg;
    logic [srp_pkg::PROD_W-1:0]   prod_abs;
    logic                         rem_nz;
    logic [srp_pkg::ANG_W+1:0]    qa_ext;
    logic [srp_pkg::ANG_W+1:0]    qa_adj;
    logic [srp_pkg::ANG_W+1:0]    floor_term;
    logic [srp_pkg::ANG_W+1:0]    ang_sum;
    logic [srp_pkg::PULSE_W-1:0]  q_ext;
    logic [srp_pkg::PULSE_W-1:0]  q_sgn;
    logic [srp_pkg::PULSE_W-1:0]  pulse_sum;
    logic                         pulse_neg;
    logic                         pulse_over;
    logic [srp_pkg::DUTY_W-1:0]   duty_new;

    srp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_steps_reg <= srp_pkg::RAMP_STEPS_RST;
            angle_min_reg  <= srp_pkg::ANGLE_MIN_RST;
            angle_max_reg  <= srp_pkg::ANGLE_MAX_RST;
            pulse_min_reg  <= srp_pkg::PULSE_MIN_RST;
            pulse_max_reg  <= srp_pkg::PULSE_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srp_pkg::REG_RAMP_STEPS: ramp_steps_reg <= cfg_wdata[srp_pkg::STEP_W-1:0];
                srp_pkg::REG_ANGLE_MIN:  angle_min_reg  <= cfg_wdata[srp_pkg::ANG_W-1:0];
                srp_pkg::REG_ANGLE_MAX:  angle_max_reg  <= cfg_wdata[srp_pkg::ANG_W-1:0];
                srp_pkg::REG_PULSE_MIN:  pulse_min_reg  <= cfg_wdata[srp_pkg::DUTY_W-1:0];
                srp_pkg::REG_PULSE_MAX:  pulse_max_reg  <= cfg_wdata[srp_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective step count: zero means one, clamp at the maximum
    always_comb
    begin
        priority if (ramp_steps_reg == '0)
            steps_eff = srp_pkg::STEP_W'(1);
        else if (ramp_steps_reg > srp_pkg::STEP_W'(srp_pkg::MAX_RAMP_STEPS))
            steps_eff = srp_pkg::STEP_W'(srp_pkg::MAX_RAMP_STEPS);
        else
            steps_eff = ramp_steps_reg;
    end

    assign tgt[0] = in_data.target_a;
    assign tgt[1] = in_data.target_b;
    assign tgt[2] = in_data.target_c;
    assign tgt[3] = in_data.target_d;
    assign tgt[4] = in_data.target_e;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    // Spans of the linear map
    assign span_in      = $signed({1'b0, angle_max_reg}) - $signed({1'b0, angle_min_reg});
    assign span_out     = $signed({1'b0, pulse_max_reg}) - $signed({1'b0, pulse_min_reg});
    assign span_in_zero = (span_in == '0);
    assign span_in_abs  = span_in[srp_pkg::DIFF_W-1] ? (~span_in + 1'b1) : span_in;

    // Multiplier operands: diff*k for the ramp, offset*span_out for the map
    always_comb
    begin
        if (state_reg == ST_MUL_B)
        begin
            mul_a = $signed({1'b0, ang_reg}) - $signed({1'b0, angle_min_reg});
            mul_b = span_out;
        end
        else
        begin
            mul_a = diff_reg[servo_reg];
            mul_b = $signed({{(srp_pkg::SPAN_OUT_W - srp_pkg::STEP_W){1'b0}}, k_reg});
        end
    end

    assign mul_p = mul_a * mul_b;

    // Divider request from the registered product
    assign prod_neg = prod_reg[srp_pkg::PROD_W-1];
    assign prod_abs = prod_neg ? (~prod_reg + 1'b1) : prod_reg;

    assign div_req.start    = (state_reg == ST_GO_A) || (state_reg == ST_GO_B);
    assign div_req.dividend = prod_abs[srp_pkg::DIV_W-1:0];
    assign div_req.divisor  = (state_reg == ST_GO_A)
                              ? {{(srp_pkg::DIVR_W - srp_pkg::STEP_W){1'b0}}, steps_reg}
                              : span_in_abs[srp_pkg::DIVR_W-1:0];

    // Floor of diff*k/steps, added to the base angle
    assign rem_nz     = (div_rsp.remainder != '0);
    assign qa_ext     = {2'b00, div_rsp.quotient[srp_pkg::ANG_W-1:0]};
    assign qa_adj     = qa_ext + {{(srp_pkg::ANG_W + 1){1'b0}}, rem_nz};
    assign floor_term = prod_neg ? (~qa_adj + 1'b1) : qa_ext;
    assign ang_sum    = {2'b00, base_reg[servo_reg]} + floor_term;

    // Truncated quotient of the map, offset by pulse_min and saturated
    assign q_ext      = {3'b000, div_rsp.quotient};
    assign q_sgn      = (prod_neg ^ span_in[srp_pkg::DIFF_W-1]) ? (~q_ext + 1'b1) : q_ext;
    assign pulse_sum  = {{(srp_pkg::PULSE_W - srp_pkg::DUTY_W){1'b0}}, pulse_min_reg} + q_sgn;
    assign pulse_neg  = pulse_sum[srp_pkg::PULSE_W-1];
    assign pulse_over = |pulse_sum[srp_pkg::PULSE_W-2:srp_pkg::DUTY_W];

    always_comb
    begin
        priority if (pulse_neg)
            duty_new = '0;
        else if (pulse_over)
            duty_new = '1;
        else
            duty_new = pulse_sum[srp_pkg::DUTY_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        servo_next = servo_reg;
        k_next     = k_reg;
        steps_next = steps_reg;
        prev_next  = prev_reg;
        base_next  = base_reg;
        diff_next  = diff_reg;
        duty_next  = duty_reg;
        ang_next   = ang_reg;
        prod_next  = prod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    for (int j = 0; j < srp_pkg::SERVO_SLOTS; j++)
                    begin
                        if (j < srp_pkg::NUM_SERVOS)
                        begin
                            base_next[j] = prev_reg[j];
                            diff_next[j] = $signed({1'b0, tgt[j]}) - $signed({1'b0, prev_reg[j]});
                            prev_next[j] = tgt[j];
                        end
                        else
                        begin
                            base_next[j] = '0;
                            diff_next[j] = '0;
                        end
                    end
                    servo_next = '0;
                    k_next     = '0;
                    steps_next = steps_eff;
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                prod_next  = mul_p;
                state_next = ST_GO_A;
            end
            ST_GO_A:
            begin
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (div_rsp.done)
                begin
                    ang_next = ang_sum[srp_pkg::ANG_W-1:0];
                    if (span_in_zero)
                    begin
                        duty_next[servo_reg] = pulse_min_reg;
                        if (servo_reg == LAST_SERVO)
                        begin
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            servo_next = servo_reg + 1'b1;
                            state_next = ST_MUL_A;
                        end
                    end
                    else
                    begin
                        state_next = ST_MUL_B;
                    end
                end
            end
            ST_MUL_B:
            begin
                prod_next  = mul_p;
                state_next = ST_GO_B;
            end
            ST_GO_B:
            begin
                state_next = ST_WAIT_B;
            end
            ST_WAIT_B:
            begin
                if (div_rsp.done)
                begin
                    duty_next[servo_reg] = duty_new;
                    if (servo_reg == LAST_SERVO)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        servo_next = servo_reg + 1'b1;
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (k_reg == steps_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        servo_next = '0;
                        state_next = ST_MUL_A;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and stored pose
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            servo_reg <= '0;
            k_reg     <= '0;
            steps_reg <= srp_pkg::STEP_W'(1);
            for (int j = 0; j < srp_pkg::SERVO_SLOTS; j++)
            begin
                prev_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            servo_reg <= servo_next;
            k_reg     <= k_next;
            steps_reg <= steps_next;
            prev_reg  <= prev_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        diff_reg <= diff_next;
        duty_reg <= duty_next;
        ang_reg  <= ang_next;
        prod_reg <= prod_next;
    end

    // Result; servos beyond the used count read as zero
    always_comb
    begin
        for (int j = 0; j < srp_pkg::SERVO_SLOTS; j++)
        begin
            duty_out[j] = (j < srp_pkg::NUM_SERVOS) ? duty_reg[j] : '0;
        end
    end

    assign out_valid           = (state_reg == ST_OUT);
    assign out_data.duty_a     = duty_out[0];
    assign out_data.duty_b     = duty_out[1];
    assign out_data.duty_c     = duty_out[2];
    assign out_data.duty_d     = duty_out[3];
    assign out_data.duty_e     = duty_out[4];
    assign out_data.ramp_index = k_reg;
    assign out_data.last_step  = (k_reg == steps_reg);

    // Checks
    `SRP_ASSERT_NXT(a_accept_starts_ramp, accept,
        (state_reg == ST_MUL_A) && (k_reg == '0) && (servo_reg == '0))
    `SRP_ASSERT_IMP(a_div_done_in_wait, div_rsp.done,
        (state_reg == ST_WAIT_A) || (state_reg == ST_WAIT_B))
    `SRP_ASSERT_NXT(a_step_advances, out_valid && !out_stall && !out_data.last_step,
        k_reg == ($past(k_reg) + 1'b1))
    `SRP_ASSERT_IMP(a_steps_nonzero, state_reg != ST_IDLE, steps_reg != '0)

endmodule

@@ sim/servo_ramp_pwm_interpolator_test.sv @@
// Self-checking bench for servo_ramp_pwm_interpolator: drives target poses and register
// writes, predicts every ramp step and compares it with the block's output requests.
// Depends on srp_pkg and the RTL of the interpolator.
module servo_ramp_pwm_interpolator_test;
    import srp_pkg::*;

    localparam int DUTY_MAX     = 16383;
    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_POSES = 130;
    localparam int ROWS         = 37;

    // Indexes past the register list; writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {ROW_WRITE, ROW_POSE, ROW_POSE_FIXED} row_kind_e;

    typedef struct {
        row_kind_e         kind;
        logic [IDX_W-1:0]  index;
        logic [CFG_W-1:0]  value;
        in_item_t          pose;
        logic [DUTY_W-1:0] duty;    // every duty of every step, fixed rows only
    } stim_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;

    // Predictor copy of the registers and the stored pose
    logic [STEP_W-1:0]  steps_reg;
    logic [ANG_W-1:0]   amin_reg;
    logic [ANG_W-1:0]   amax_reg;
    logic [DUTY_W-1:0]  pmin_reg;
    logic [DUTY_W-1:0]  pmax_reg;
    logic [ANG_W-1:0]   held_pose [SERVO_SLOTS];

    out_item_t          pending_steps [$];
    stim_row_t          directed_rows [ROWS];
    int                 fail_count  = 0;
    int                 sender_pct  = 0;
    int                 stall_pct   = 0;
    int                 idle_cycles = 0;

    servo_ramp_pwm_interpolator i_dut (.*);

    always #5 clk = ~clk;

    // Floor division, divisor always positive
    function automatic int floor_quot(int num, int den);
        int q;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q;
    endfunction

    // Linear angle to duty mapping, truncating division, saturated to 14 bits
    function automatic logic [DUTY_W-1:0] angle_to_pulse(int angle);
        int span_in;
        int span_out;
        int pulse;
        span_in  = int'(amax_reg) - int'(amin_reg);
        span_out = int'(pmax_reg) - int'(pmin_reg);
        if (span_in == 0)
            return pmin_reg;
        pulse = (angle - int'(amin_reg)) * span_out / span_in + int'(pmin_reg);
        if (pulse < 0)
            pulse = 0;
        if (pulse > DUTY_MAX)
            pulse = DUTY_MAX;
        return pulse[DUTY_W-1:0];
    endfunction

    // Queue every step of the ramp towards a pose and store the pose
    function automatic void plan_ramp(in_item_t pose);
        int                steps;
        int                k;
        int                j;
        int                base [SERVO_SLOTS];
        int                diff [SERVO_SLOTS];
        logic [ANG_W-1:0]  tgt  [SERVO_SLOTS];
        logic [DUTY_W-1:0] duty [SERVO_SLOTS];
        out_item_t         step_item;
        tgt = '{pose.target_a, pose.target_b, pose.target_c, pose.target_d, pose.target_e};
        // zero steps behaves as one
        steps = (steps_reg == 0) ? 1 : int'(steps_reg);
        if (steps > MAX_RAMP_STEPS)
            steps = MAX_RAMP_STEPS;
        for (j = 0; j < SERVO_SLOTS; j++)
        begin
            base[j] = 0;
            diff[j] = 0;
            if (j < NUM_SERVOS)
            begin
                base[j]      = int'(held_pose[j]);
                diff[j]      = int'(tgt[j]) - base[j];
                held_pose[j] = tgt[j];
            end
        end
        for (k = 0; k <= steps; k++)
        begin
            for (j = 0; j < SERVO_SLOTS; j++)
                duty[j] = (j < NUM_SERVOS) ?
                          angle_to_pulse(base[j] + floor_quot(diff[j] * k, steps)) : '0;
            step_item.duty_a     = duty[0];
            step_item.duty_b     = duty[1];
            step_item.duty_c     = duty[2];
            step_item.duty_d     = duty[3];
            step_item.duty_e     = duty[4];
            step_item.ramp_index = k[STEP_W-1:0];
            step_item.last_step  = (k == steps);
            pending_steps.push_back(step_item);
        end
    endfunction

    function automatic void check_field(string name, logic [DUTY_W-1:0] want,
                                        logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Register write, one cycle, model follows with the register's width
    task automatic write_reg(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (index)
            REG_RAMP_STEPS: steps_reg = value[STEP_W-1:0];
            REG_ANGLE_MIN:  amin_reg  = value[ANG_W-1:0];
            REG_ANGLE_MAX:  amax_reg  = value[ANG_W-1:0];
            REG_PULSE_MIN:  pmin_reg  = value[DUTY_W-1:0];
            REG_PULSE_MAX:  pmax_reg  = value[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Every pose yields results, so idle means nothing left to arrive
    task automatic drain_ramps();
        in_valid = 1'b0;
        while (pending_steps.size() != 0)
            @(negedge clk);
    endtask

    // One pose request; a fixed duty overrides the predicted duties
    task automatic send_pose(in_item_t pose, bit fixed, logic [DUTY_W-1:0] duty);
        int first;
        int i;
        while ($urandom_range(99) < sender_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = pose;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        first = pending_steps.size();
        plan_ramp(pose);
        if (fixed)
        begin
            for (i = first; i < pending_steps.size(); i++)
            begin
                pending_steps[i].duty_a = duty;
                pending_steps[i].duty_b = duty;
                pending_steps[i].duty_c = duty;
                pending_steps[i].duty_d = duty;
                pending_steps[i].duty_e = duty;
            end
        end
        @(negedge clk);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    // Compare each accepted step with the oldest prediction
    always @(posedge clk)
    begin : step_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_steps.size() == 0)
            begin
                $error("ramp step with no pose pending, ramp_index %0d", out_data.ramp_index);
                fail_count++;
            end
            else
            begin
                want = pending_steps.pop_front();
                check_field("duty_a", want.duty_a, out_data.duty_a);
                check_field("duty_b", want.duty_b, out_data.duty_b);
                check_field("duty_c", want.duty_c, out_data.duty_c);
                check_field("duty_d", want.duty_d, out_data.duty_d);
                check_field("duty_e", want.duty_e, out_data.duty_e);
                check_field("ramp_index", want.ramp_index, out_data.ramp_index);
                check_field("last_step", want.last_step, out_data.last_step);
            end
        end
    end

    // Watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int               row;
        int               done;
        int               phase;
        int               n;
        int               j;
        int               pick;
        int               a_lo;
        int               a_hi;
        logic [STEP_W-1:0] steps;
        logic [ANG_W-1:0] angles [SERVO_SLOTS];
        in_item_t         pose;

        steps_reg = RAMP_STEPS_RST;
        amin_reg  = ANGLE_MIN_RST;
        amax_reg  = ANGLE_MAX_RST;
        pmin_reg  = PULSE_MIN_RST;
        pmax_reg  = PULSE_MAX_RST;
        foreach (held_pose[j])
            held_pose[j] = '0;

        directed_rows = '{
            // from reset: rest pose maps to pulse_min
            '{ROW_POSE_FIXED, '0, '0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 14'd410},
            '{ROW_POSE, '0, '0, {8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, '0},
            '{ROW_POSE, '0, '0, {8'd0, 8'd255, 8'd0, 8'd255, 8'd128}, '0},
            // zero steps gives two results
            '{ROW_WRITE, REG_RAMP_STEPS, 14'd0, '0, '0},
            '{ROW_POSE, '0, '0, {8'd17, 8'd200, 8'd3, 8'd99, 8'd255}, '0},
            '{ROW_WRITE, REG_RAMP_STEPS, 14'd63, '0, '0},
            '{ROW_POSE, '0, '0, {8'd255, 8'd0, 8'd255, 8'd0, 8'd1}, '0},
            '{ROW_WRITE, REG_RAMP_STEPS, 14'd2, '0, '0},
            // equal angle bounds: duty is pulse_min throughout
            '{ROW_WRITE, REG_ANGLE_MAX, 14'd0, '0, '0},
            '{ROW_POSE_FIXED, '0, '0, {8'd90, 8'd45, 8'd255, 8'd0, 8'd170}, 14'd410},
            '{ROW_WRITE, REG_PULSE_MIN, 14'd16383, '0, '0},
            '{ROW_POSE_FIXED, '0, '0, {8'd0, 8'd255, 8'd1, 8'd254, 8'd128}, 14'd16383},
            // full range mapping
            '{ROW_WRITE, REG_ANGLE_MAX, 14'd255, '0, '0},
            '{ROW_WRITE, REG_PULSE_MIN, 14'd0, '0, '0},
            '{ROW_WRITE, REG_PULSE_MAX, 14'd16383, '0, '0},
            '{ROW_POSE, '0, '0, {8'd255, 8'd0, 8'd128, 8'd1, 8'd254}, '0},
            // steep mapping: saturation at both ends
            '{ROW_WRITE, REG_ANGLE_MIN, 14'd100, '0, '0},
            '{ROW_WRITE, REG_ANGLE_MAX, 14'd101, '0, '0},
            '{ROW_POSE, '0, '0, {8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, '0},
            '{ROW_POSE_FIXED, '0, '0, {8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 14'd16383},
            '{ROW_POSE, '0, '0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, '0},
            '{ROW_POSE_FIXED, '0, '0, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 14'd0},
            // inverted bounds and falling pulse range
            '{ROW_WRITE, REG_ANGLE_MIN, 14'd200, '0, '0},
            '{ROW_WRITE, REG_ANGLE_MAX, 14'd20, '0, '0},
            '{ROW_WRITE, REG_PULSE_MIN, 14'd3000, '0, '0},
            '{ROW_WRITE, REG_PULSE_MAX, 14'd500, '0, '0},
            '{ROW_POSE, '0, '0, {8'd37, 8'd211, 8'd160, 8'd5, 8'd90}, '0},
            // writes past the register list are ignored
            '{ROW_WRITE, REG_SPARE_5, 14'h3fff, '0, '0},
            '{ROW_WRITE, REG_SPARE_6, 14'h0000, '0, '0},
            '{ROW_WRITE, REG_SPARE_7, 14'h1234, '0, '0},
            '{ROW_POSE, '0, '0, {8'd200, 8'd20, 8'd100, 8'd255, 8'd0}, '0},
            // upper write data bits dropped on narrow registers
            '{ROW_WRITE, REG_ANGLE_MIN, 14'h3f05, '0, '0},
            '{ROW_WRITE, REG_RAMP_STEPS, 14'h3fc3, '0, '0},
            '{ROW_WRITE, REG_ANGLE_MAX, 14'h3e80, '0, '0},
            '{ROW_POSE, '0, '0, {8'd5, 8'd128, 8'd66, 8'd250, 8'd3}, '0},
            '{ROW_WRITE, REG_ANGLE_MIN, 14'd255, '0, '0},
            '{ROW_POSE, '0, '0, {8'd255, 8'd0, 8'd129, 8'd127, 8'd200}, '0}
        };

        sender_pct = 27;
        stall_pct  = 47;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        for (row = 0; row < ROWS; row++)
        begin
            if (directed_rows[row].kind == ROW_WRITE)
            begin
                drain_ramps();
                write_reg(directed_rows[row].index, directed_rows[row].value);
            end
            else
                send_pose(directed_rows[row].pose, directed_rows[row].kind == ROW_POSE_FIXED,
                          directed_rows[row].duty);
        end

        // Random phases: new settings, then a run of poses
        done  = 0;
        phase = 0;
        while (done < RANDOM_POSES)
        begin
            if (done < RANDOM_POSES / 3)
            begin
                sender_pct = 27;
                stall_pct  = 47;
            end
            else if (done < 2 * RANDOM_POSES / 3)
            begin
                sender_pct = 47;
                stall_pct  = 27;
            end
            else
            begin
                sender_pct = 0;
                stall_pct  = 0;
            end
            drain_ramps();

            // long ramps are slow, so only a couple of phases use them
            if (phase == 2 || phase == 6)
                steps = 6'd63;
            else if (phase == 4)
                steps = 6'd0;
            else
                steps = STEP_W'($urandom_range(1, 6));
            write_reg(REG_RAMP_STEPS, {8'($urandom), steps});

            pick = $urandom_range(9);
            if (pick == 0)
            begin
                a_lo = $urandom_range(255);
                a_hi = a_lo;
            end
            else if (pick == 1)
            begin
                a_lo = $urandom_range(128, 255);
                a_hi = $urandom_range(0, 127);
            end
            else
            begin
                a_lo = $urandom_range(0, 80);
                a_hi = $urandom_range(100, 255);
            end
            write_reg(REG_ANGLE_MIN, {6'($urandom), 8'(a_lo)});
            write_reg(REG_ANGLE_MAX, {6'($urandom), 8'(a_hi)});
            write_reg(REG_PULSE_MIN, 14'($urandom));
            write_reg(REG_PULSE_MAX, 14'($urandom));

            n = (steps_reg > 8) ? 2 : 18;
            repeat (n)
            begin
                // mostly fresh angles, some held poses and end stops
                pick = $urandom_range(9);
                for (j = 0; j < SERVO_SLOTS; j++)
                begin
                    if (pick == 0)
                        angles[j] = held_pose[j];
                    else if (pick == 1)
                        angles[j] = $urandom_range(1) ? 8'd255 : 8'd0;
                    else
                        angles[j] = 8'($urandom);
                end
                pose = {angles[0], angles[1], angles[2], angles[3], angles[4]};
                send_pose(pose, 1'b0, '0);
                done++;
            end
            phase++;
        end

        drain_ramps();
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
